// ----- hw/rtl/utf8d_pkg.sv -----
`default_nettype none

package utf8d_pkg;

  localparam int unsigned CpW = 21;
  localparam int unsigned ByteW = 8;
  localparam int unsigned CntW = 3;

  localparam logic [CpW-1:0] ReplChar = 21'h00FFFD;
  localparam logic [CpW-1:0] MaxScalar = 21'h10FFFF;
  localparam logic [CpW-1:0] SurrLo = 21'h00D800;
  localparam logic [CpW-1:0] SurrHi = 21'h00DFFF;
  localparam logic [CpW-1:0] Min2 = 21'h000080;
  localparam logic [CpW-1:0] Min3 = 21'h000800;
  localparam logic [CpW-1:0] Min4 = 21'h010000;

  localparam logic [CntW-1:0] LenIdle = 3'd0;
  localparam logic [CntW-1:0] Len2 = 3'd2;
  localparam logic [CntW-1:0] Len3 = 3'd3;
  localparam logic [CntW-1:0] Len4 = 3'd4;

  // results of one byte: rep_cnt replacements, then an optional tail result
  typedef struct packed {
    logic [CntW-1:0] rep_cnt;
    logic            tail_vld;
    logic [CpW-1:0]  tail_cp;
    logic            tail_rep;
    logic            tail_eot;
  } burst_t;

endpackage

`default_nettype wire

// ----- hw/rtl/utf8d_decode.sv -----
`default_nettype none

module utf8d_decode (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     accept_i,
  input  wire logic [7:0]               byte_i,
  output      utf8d_pkg::burst_t        desc_o
);
  import utf8d_pkg::*;

  logic [CpW-1:0]  pv_q, pv_d;
  logic [CntW-1:0] len_q, len_d;
  logic [1:0]      taken_q, taken_d;

  logic            open_seq;
  logic            cont;
  logic [CntW-1:0] taken_inc;
  logic [CpW-1:0]  pv_shift;
  logic [CpW-1:0]  min_val;
  logic            ok;
  burst_t          desc;

  assign open_seq  = (len_q == Len2) || (len_q == Len3) || (len_q == Len4);
  assign cont      = (byte_i[7:6] == 2'b10);
  assign taken_inc = {1'b0, taken_q} + 3'd1;
  assign pv_shift  = {pv_q[CpW-7:0], byte_i[5:0]};

  always_comb begin
    unique case (len_q)
      Len2:    min_val = Min2;
      Len3:    min_val = Min3;
      default: min_val = Min4;
    endcase
  end

  assign ok = (pv_shift >= min_val) && (pv_shift <= MaxScalar) &&
              !((pv_shift >= SurrLo) && (pv_shift <= SurrHi));

  always_comb begin
    pv_d    = pv_q;
    len_d   = len_q;
    taken_d = taken_q;
    desc    = '0;
    if (open_seq && cont) begin
      if (taken_inc < len_q) begin
        pv_d    = pv_shift;
        taken_d = taken_inc[1:0];
      end else begin
        pv_d    = '0;
        len_d   = LenIdle;
        taken_d = '0;
        if (ok) begin
          desc.tail_vld = 1'b1;
          desc.tail_cp  = pv_shift;
        end else begin
          desc.rep_cnt = len_q;
        end
      end
    end else begin
      // flush of an interrupted sequence
      if (open_seq) begin
        desc.rep_cnt = {1'b0, taken_q};
      end
      pv_d    = '0;
      len_d   = LenIdle;
      taken_d = '0;
      priority if (byte_i == 8'h00) begin
        desc.tail_vld = 1'b1;
        desc.tail_eot = 1'b1;
      end else if (!byte_i[7]) begin
        desc.tail_vld = 1'b1;
        desc.tail_cp  = {13'd0, byte_i};
      end else if (byte_i[7:5] == 3'b110) begin
        pv_d    = {16'd0, byte_i[4:0]};
        len_d   = Len2;
        taken_d = 2'd1;
      end else if (byte_i[7:4] == 4'b1110) begin
        pv_d    = {17'd0, byte_i[3:0]};
        len_d   = Len3;
        taken_d = 2'd1;
      end else if (byte_i[7:3] == 5'b11110) begin
        pv_d    = {18'd0, byte_i[2:0]};
        len_d   = Len4;
        taken_d = 2'd1;
      end else begin
        desc.tail_vld = 1'b1;
        desc.tail_cp  = ReplChar;
        desc.tail_rep = 1'b1;
      end
    end
  end

  assign desc_o = desc;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pv_q    <= '0;
      len_q   <= LenIdle;
      taken_q <= '0;
    end else if (accept_i) begin
      pv_q    <= pv_d;
      len_q   <= len_d;
      taken_q <= taken_d;
    end
  end

`ifndef SYNTHESIS
  a_len_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (len_q == LenIdle) || open_seq)
    else $error("sequence length code out of range");
  a_taken_below_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    open_seq |-> (({1'b0, taken_q} < len_q) && (taken_q != 2'd0)))
    else $error("bytes taken not within open sequence");
  a_idle_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (len_q == LenIdle) |-> ((pv_q == '0) && (taken_q == 2'd0)))
    else $error("idle state holds partial data");
`endif

endmodule

`default_nettype wire

// ----- hw/rtl/utf8d_burst.sv -----
`default_nettype none

module utf8d_burst (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         load_i,
  input  wire utf8d_pkg::burst_t            desc_i,
  output      logic                         free_o,
  output      logic                         valid_o,
  input  wire logic                         ready_i,
  output      logic [utf8d_pkg::CpW-1:0]    code_point_o,
  output      logic                         replaced_o,
  output      logic                         eot_o,
  output      logic                         last_o
);
  import utf8d_pkg::*;

  logic [CntW-1:0] rep_left_q, rep_left_d;
  logic            tail_q, tail_d;
  logic [CpW-1:0]  tail_cp_q;
  logic            tail_rep_q;
  logic            tail_eot_q;
  logic [CntW-1:0] remain;
  logic            xfer;

  assign remain  = rep_left_q + {2'b00, tail_q};
  assign valid_o = (remain != '0);
  assign xfer    = valid_o && ready_i;
  assign free_o  = !valid_o || (xfer && (remain == 3'd1));

  always_comb begin
    if (rep_left_q != '0) begin
      code_point_o = ReplChar;
      replaced_o   = 1'b1;
      eot_o        = 1'b0;
      last_o       = (rep_left_q == 3'd1) && !tail_q;
    end else begin
      code_point_o = tail_cp_q;
      replaced_o   = tail_rep_q;
      eot_o        = tail_eot_q;
      last_o       = 1'b1;
    end
  end

  always_comb begin
    rep_left_d = rep_left_q;
    tail_d     = tail_q;
    if (xfer) begin
      if (rep_left_q != '0) begin
        rep_left_d = rep_left_q - 3'd1;
      end else begin
        tail_d = 1'b0;
      end
    end
    if (load_i) begin
      rep_left_d = desc_i.rep_cnt;
      tail_d     = desc_i.tail_vld;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rep_left_q <= '0;
      tail_q     <= 1'b0;
    end else begin
      rep_left_q <= rep_left_d;
      tail_q     <= tail_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      tail_cp_q  <= desc_i.tail_cp;
      tail_rep_q <= desc_i.tail_rep;
      tail_eot_q <= desc_i.tail_eot;
    end
  end

`ifndef SYNTHESIS
  a_remain_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    remain <= 3'd4)
    else $error("burst holds more than four results");
  a_load_when_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_i |-> free_o)
    else $error("burst loaded while results pending");
  a_last_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (xfer && last_o && !load_i) |=> !valid_o)
    else $error("results remain after last transaction");
  a_eot_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && eot_o) |-> (!replaced_o && (code_point_o == '0) && last_o))
    else $error("end of text result malformed");
`endif

endmodule

`default_nettype wire

// ----- hw/rtl/utf8_codepoint_decoder.sv -----
// output: a result is registered and appears in the cycle after the byte that completes it
// throughput: one byte per cycle while each byte gives at most one result and m_axis_tready does not stall the output
// a byte giving several results stalls the input until its last result is taken (burst register)
// reset: asynchronous active low, decoder returns to idle and pending results are dropped
`default_nettype none

module utf8_codepoint_decoder (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output      logic        s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,   // [7:0] in_byte
  output      logic        m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output      logic [23:0] m_axis_tdata,   // [20:0] code_point, [23:21] zero
  output      logic [1:0]  m_axis_tuser,   // [0] replaced, [1] end_of_text
  output      logic        m_axis_tlast
);
  import utf8d_pkg::*;

  logic           accept;
  logic           free;
  burst_t         desc;
  logic [CpW-1:0] code_point;
  logic           replaced;
  logic           eot;

  assign s_axis_tready = free;
  assign accept        = s_axis_tvalid && free;

  utf8d_decode u_decode (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .byte_i   (s_axis_tdata),
    .desc_o   (desc)
  );

  utf8d_burst u_burst (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .load_i       (accept),
    .desc_i       (desc),
    .free_o       (free),
    .valid_o      (m_axis_tvalid),
    .ready_i      (m_axis_tready),
    .code_point_o (code_point),
    .replaced_o   (replaced),
    .eot_o        (eot),
    .last_o       (m_axis_tlast)
  );

  assign m_axis_tdata = {3'b000, code_point};
  assign m_axis_tuser = {eot, replaced};

endmodule

`default_nettype wire
